/* design/lrk4_pkg.sv */
// Shared types, constants and micro-program for the Lorenz RK4 integrator.
`timescale 1ns / 1ps
`default_nettype none
package lrk4_pkg;

	localparam int STRIDE    = 4;
	localparam int FRAC_BITS = 24;
	localparam int PHASE_W   = (STRIDE > 1) ? $clog2(STRIDE) : 1;

	localparam int VAL_W   = 40;              // state and stage values
	localparam int ACC_W   = 44;              // k1 + 2k2 + 2k3 + k4 and scratch T
	localparam int WIDE_W  = ACC_W + 1;       // operand bus
	localparam int SUM_W   = WIDE_W + 1;
	localparam int CNT_W   = 32;
	localparam int H_W     = 25;
	localparam int COEF_W  = 32;
	localparam int TRANS_W = 20;
	localparam int CFG_AW  = 3;
	localparam int CFG_DW  = 40;

	// shared multiplier: 44 x 48 bit magnitudes, 16 bits of B per cycle
	localparam int OPA_W   = 44;
	localparam int OPB_W   = 48;
	localparam int CHUNK_W = 16;
	localparam int N_CHUNK = OPB_W / CHUNK_W;
	localparam int CHK_CW  = $clog2(N_CHUNK + 1);
	localparam int PROD_W  = OPA_W + OPB_W;
	localparam int Q_W     = PROD_W - FRAC_BITS;

	// divide by six as multiply by ceil(2^45 / 6), exact below 2^42
	localparam int DIV_SH = 45;
	localparam logic [42:0] RECIP6 = 43'd5864062014806;
	localparam logic [Q_W-1:0] MULF_LIM = Q_W'((64'd1 << 42) - 64'd4);

	localparam logic [H_W-1:0]     RST_STEP  = H_W'(83886);
	localparam logic [COEF_W-1:0]  RST_SIGMA = COEF_W'(167772160);
	localparam logic [COEF_W-1:0]  RST_RHO   = COEF_W'(469762048);
	localparam logic [COEF_W-1:0]  RST_BETA  = COEF_W'(44739243);
	localparam logic [VAL_W-1:0]   RST_POS   = VAL_W'(16777216);
	localparam logic [TRANS_W-1:0] RST_TRANS = TRANS_W'(1000);

	localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W - 1){1'b1}}};
	localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W - 1){1'b0}}};

	typedef logic signed [WIDE_W-1:0] wide_t;

	typedef enum logic [CFG_AW-1:0] {
		REG_STEP  = 3'd0,
		REG_SIGMA = 3'd1,
		REG_RHO   = 3'd2,
		REG_BETA  = 3'd3,
		REG_SX    = 3'd4,
		REG_SY    = 3'd5,
		REG_SZ    = 3'd6,
		REG_TRANS = 3'd7
	} cfg_reg_t;

	typedef enum logic [1:0] {SH_FRAC, SH_HALF, SH_DIV} shift_t;

	typedef enum logic [2:0] {
		OP_NOP, OP_SUB, OP_ADD, OP_MUL, OP_ACC, OP_MULF, OP_DIV
	} op_t;

	typedef enum logic [4:0] {
		SRC_S0, SRC_S1, SRC_S2, SRC_Y0, SRC_Y1, SRC_Y2, SRC_K0, SRC_K1, SRC_K2,
		SRC_T, SRC_T2, SRC_SIG, SRC_RHO, SRC_BETA, SRC_H,
		SRC_A0, SRC_A1, SRC_A2, SRC_RCP
	} src_t;

	typedef enum logic [3:0] {
		DST_S0, DST_S1, DST_S2, DST_Y0, DST_Y1, DST_Y2, DST_K0, DST_K1, DST_K2,
		DST_T, DST_T2, DST_A0, DST_A1, DST_A2
	} dst_t;

	typedef enum logic [1:0] {W_SET, W_ONE, W_TWO} weight_t;

	typedef struct packed {
		op_t     op;
		src_t    a;
		src_t    b;
		dst_t    d;
		shift_t  sh;
		weight_t w;
	} uop_t;

	typedef struct packed {
		logic              go;
		logic [OPA_W-1:0]  a;
		logic [OPB_W-1:0]  b;
		shift_t            sh;
	} mul_req_t;

	typedef struct packed {
		logic go;
		logic load;
	} core_cmd_t;

	typedef struct packed {
		logic idle;
		logic done;
	} core_sts_t;

	typedef struct packed {
		logic [H_W-1:0]    h;
		logic [COEF_W-1:0] sigma;
		logic [COEF_W-1:0] rho;
		logic [COEF_W-1:0] beta;
	} coef_t;

	typedef struct packed {
		logic [VAL_W-1:0] z;
		logic [VAL_W-1:0] y;
		logic [VAL_W-1:0] x;
	} pos_t;

	function automatic uop_t mk(input op_t op, input src_t a, input src_t b, input dst_t d,
			input shift_t sh, input weight_t w);
		uop_t u;
		u.op = op; u.a = a; u.b = b; u.d = d; u.sh = sh; u.w = w;
		return u;
	endfunction

	// last slot of each RK stage
	function automatic logic [4:0] last_slot(input logic [1:0] stage);
		return (stage == 2'd3) ? 5'd19 : 5'd16;
	endfunction

	// micro-program: slots 0..7 evaluate the derivative, 8..10 build the
	// weighted k sum, the rest form the next stage input or the new position
	function automatic uop_t uop_at(input logic [1:0] stage, input logic [4:0] slot);
		uop_t    u;
		weight_t w;
		shift_t  hs;
		logic    fin;
		fin = (stage == 2'd3);
		w   = (stage == 2'd0) ? W_SET : (fin ? W_ONE : W_TWO);
		hs  = (stage == 2'd2) ? SH_FRAC : SH_HALF;
		u   = mk(OP_NOP, SRC_S0, SRC_S0, DST_T, SH_FRAC, W_SET);
		case (slot)
			5'd0: u = mk(OP_SUB, SRC_S1, SRC_S0, DST_T, SH_FRAC, w);
			5'd1: u = mk(OP_MUL, SRC_SIG, SRC_T, DST_K0, SH_FRAC, w);
			5'd2: u = mk(OP_SUB, SRC_RHO, SRC_S2, DST_T, SH_FRAC, w);
			5'd3: u = mk(OP_MUL, SRC_S0, SRC_T, DST_T, SH_FRAC, w);
			5'd4: u = mk(OP_SUB, SRC_T, SRC_S1, DST_K1, SH_FRAC, w);
			5'd5: u = mk(OP_MUL, SRC_S0, SRC_S1, DST_T, SH_FRAC, w);
			5'd6: u = mk(OP_MUL, SRC_BETA, SRC_S2, DST_T2, SH_FRAC, w);
			5'd7: u = mk(OP_SUB, SRC_T, SRC_T2, DST_K2, SH_FRAC, w);
			5'd8: u = mk(OP_ACC, SRC_K0, SRC_A0, DST_A0, SH_FRAC, w);
			5'd9: u = mk(OP_ACC, SRC_K1, SRC_A1, DST_A1, SH_FRAC, w);
			5'd10: u = mk(OP_ACC, SRC_K2, SRC_A2, DST_A2, SH_FRAC, w);
			5'd11: u = fin ? mk(OP_MULF, SRC_A0, SRC_H, DST_T, SH_FRAC, w)
				: mk(OP_MUL, SRC_K0, SRC_H, DST_T, hs, w);
			5'd12: u = fin ? mk(OP_DIV, SRC_T, SRC_RCP, DST_T, SH_DIV, w)
				: mk(OP_ADD, SRC_Y0, SRC_T, DST_S0, SH_FRAC, w);
			5'd13: u = fin ? mk(OP_ADD, SRC_Y0, SRC_T, DST_Y0, SH_FRAC, w)
				: mk(OP_MUL, SRC_K1, SRC_H, DST_T, hs, w);
			5'd14: u = fin ? mk(OP_MULF, SRC_A1, SRC_H, DST_T, SH_FRAC, w)
				: mk(OP_ADD, SRC_Y1, SRC_T, DST_S1, SH_FRAC, w);
			5'd15: u = fin ? mk(OP_DIV, SRC_T, SRC_RCP, DST_T, SH_DIV, w)
				: mk(OP_MUL, SRC_K2, SRC_H, DST_T, hs, w);
			5'd16: u = fin ? mk(OP_ADD, SRC_Y1, SRC_T, DST_Y1, SH_FRAC, w)
				: mk(OP_ADD, SRC_Y2, SRC_T, DST_S2, SH_FRAC, w);
			5'd17: u = mk(OP_MULF, SRC_A2, SRC_H, DST_T, SH_FRAC, w);
			5'd18: u = mk(OP_DIV, SRC_T, SRC_RCP, DST_T, SH_DIV, w);
			5'd19: u = mk(OP_ADD, SRC_Y2, SRC_T, DST_Y2, SH_FRAC, w);
			default: u = mk(OP_NOP, SRC_S0, SRC_S0, DST_T, SH_FRAC, w);
		endcase
		return u;
	endfunction

	// clamp a sum to the 40-bit signed range
	function automatic logic signed [VAL_W-1:0] sat_sum(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] hi;
		logic signed [SUM_W-1:0] lo;
		hi = SUM_W'(VAL_MAX);
		lo = SUM_W'(VAL_MIN);
		if (v > hi)
			return VAL_MAX;
		else if (v < lo)
			return VAL_MIN;
		else
			return v[VAL_W-1:0];
	endfunction

	// apply sign to a product magnitude and clamp to 40 bits
	function automatic logic signed [VAL_W-1:0] sat_mag(input logic [Q_W-1:0] q, input logic neg);
		logic [Q_W-1:0] lim;
		lim = Q_W'(1) << (VAL_W - 1);
		if (neg)
			return (q >= lim) ? VAL_MIN : -$signed(q[VAL_W-1:0]);
		else
			return (q >= lim) ? VAL_MAX : $signed(q[VAL_W-1:0]);
	endfunction

endpackage
`default_nettype wire

/* design/lrk4_mul.sv */
// Shared multi-cycle multiplier with a right shift, rounded except on the divide shift.
`timescale 1ns / 1ps
`default_nettype none
module lrk4_mul
	import lrk4_pkg::*;
(
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire mul_req_t       req,
	output logic [Q_W-1:0]      q,
	output logic                done
);

	logic [OPA_W-1:0]   a_q;
	logic [OPB_W-1:0]   b_q;
	logic [PROD_W-1:0]  acc_q;
	logic [CHK_CW-1:0]  cnt_q;
	shift_t             sh_q;
	logic               busy_q;
	logic               done_q;
	logic [Q_W-1:0]     q_q;

	logic [OPA_W+CHUNK_W-1:0] pp;
	logic [PROD_W-1:0]        pp_pos;
	logic [PROD_W:0]          rnd;
	logic [PROD_W:0]          rsum;
	logic [Q_W-1:0]           q_next;

	// one partial product of A by 16 bits of B
	assign pp     = a_q * b_q[CHUNK_W-1:0];
	assign pp_pos = PROD_W'(pp) << (CHUNK_W * 32'(cnt_q));

	// round to nearest on the magnitude (no rounding for the divide shift), then shift
	always_comb begin
		case (sh_q)
			SH_FRAC: rnd = (PROD_W + 1)'(1) << (FRAC_BITS - 1);
			SH_HALF: rnd = (PROD_W + 1)'(1) << FRAC_BITS;
			default: rnd = '0;
		endcase
		rsum = {1'b0, acc_q} + rnd;
		case (sh_q)
			SH_FRAC: q_next = Q_W'(rsum >> FRAC_BITS);
			SH_HALF: q_next = Q_W'(rsum >> (FRAC_BITS + 1));
			default: q_next = Q_W'(rsum >> DIV_SH);
		endcase
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CHK_CW'(N_CHUNK)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	// operands and accumulator
	always_ff @(posedge clk) begin
		if (req.go) begin
			a_q   <= req.a;
			b_q   <= req.b;
			sh_q  <= req.sh;
			acc_q <= '0;
		end else if (busy_q) begin
			if (cnt_q == CHK_CW'(N_CHUNK)) begin
				q_q <= q_next;
			end else begin
				acc_q <= acc_q + pp_pos;
				b_q   <= b_q >> CHUNK_W;
			end
		end
	end

	assign q    = q_q;
	assign done = done_q;

endmodule
`default_nettype wire

/* design/lrk4_core.sv */
// Micro-sequenced RK4 datapath around the shared multiplier.
`timescale 1ns / 1ps
`default_nettype none
module lrk4_core
	import lrk4_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire core_cmd_t  cmd,
	input  wire coef_t      coef,
	input  wire pos_t       start,
	input  wire logic       fin_ok,
	output core_sts_t       sts,
	output pos_t            pos
);

	typedef enum logic [3:0] {
		SQ_IDLE = 4'b0001,
		SQ_EXEC = 4'b0010,
		SQ_WAIT = 4'b0100,
		SQ_DONE = 4'b1000
	} seq_t;

	seq_t       state_q;
	logic [1:0] stage_q;
	logic [4:0] slot_q;
	logic       neg_q;

	logic signed [VAL_W-1:0] s0_q, s1_q, s2_q;
	logic signed [VAL_W-1:0] y0_q, y1_q, y2_q;
	logic signed [VAL_W-1:0] k0_q, k1_q, k2_q;
	logic signed [VAL_W-1:0] t2_q;
	logic signed [ACC_W-1:0] t_q;
	logic signed [ACC_W-1:0] a0_q, a1_q, a2_q;

	uop_t          u;
	wide_t         opa, opb, maga, magb;
	logic          neg;
	logic          is_mul;
	logic          adv;
	logic          wr_en;
	wide_t         wr_val;
	mul_req_t      mreq;
	logic [Q_W-1:0] mq;
	logic          mdone;
	logic [Q_W-1:0] mf_val;

	assign u      = uop_at(stage_q, slot_q);
	assign is_mul = (u.op == OP_MUL) || (u.op == OP_MULF) || (u.op == OP_DIV);

	// operand select
	always_comb begin
		case (u.a)
			SRC_S0:   opa = WIDE_W'(s0_q);
			SRC_S1:   opa = WIDE_W'(s1_q);
			SRC_S2:   opa = WIDE_W'(s2_q);
			SRC_Y0:   opa = WIDE_W'(y0_q);
			SRC_Y1:   opa = WIDE_W'(y1_q);
			SRC_Y2:   opa = WIDE_W'(y2_q);
			SRC_K0:   opa = WIDE_W'(k0_q);
			SRC_K1:   opa = WIDE_W'(k1_q);
			SRC_K2:   opa = WIDE_W'(k2_q);
			SRC_T:    opa = WIDE_W'(t_q);
			SRC_T2:   opa = WIDE_W'(t2_q);
			SRC_SIG:  opa = $signed({{(WIDE_W - COEF_W){1'b0}}, coef.sigma});
			SRC_RHO:  opa = $signed({{(WIDE_W - COEF_W){1'b0}}, coef.rho});
			SRC_BETA: opa = $signed({{(WIDE_W - COEF_W){1'b0}}, coef.beta});
			SRC_A0:   opa = WIDE_W'(a0_q);
			SRC_A1:   opa = WIDE_W'(a1_q);
			SRC_A2:   opa = WIDE_W'(a2_q);
			default:  opa = WIDE_W'(s0_q);
		endcase
		case (u.b)
			SRC_S0:  opb = WIDE_W'(s0_q);
			SRC_S1:  opb = WIDE_W'(s1_q);
			SRC_S2:  opb = WIDE_W'(s2_q);
			SRC_Y0:  opb = WIDE_W'(y0_q);
			SRC_T:   opb = WIDE_W'(t_q);
			SRC_T2:  opb = WIDE_W'(t2_q);
			SRC_H:   opb = $signed({{(WIDE_W - H_W){1'b0}}, coef.h});
			SRC_A0:  opb = WIDE_W'(a0_q);
			SRC_A1:  opb = WIDE_W'(a1_q);
			SRC_A2:  opb = WIDE_W'(a2_q);
			SRC_RCP: opb = $signed({{(WIDE_W - 43){1'b0}}, RECIP6});
			default: opb = WIDE_W'(y1_q);
		endcase
	end

	// magnitudes and product sign for the multiplier
	assign maga = opa[WIDE_W-1] ? -opa : opa;
	assign magb = opb[WIDE_W-1] ? -opb : opb;
	assign neg  = opa[WIDE_W-1] ^ opb[WIDE_W-1];

	always_comb begin
		mreq.go = (state_q == SQ_EXEC) && is_mul;
		mreq.a  = (u.op == OP_DIV) ? (OPA_W'($unsigned(t_q)) + OPA_W'(3))
			: OPA_W'($unsigned(maga));
		mreq.b  = OPB_W'($unsigned(magb));
		mreq.sh = u.sh;
	end

	lrk4_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.q      (mq),
		.done   (mdone)
	);

	assign mf_val = (mq > MULF_LIM) ? MULF_LIM : mq;

	// result of the current micro-op
	always_comb begin
		wr_val = '0;
		case (u.op)
			OP_SUB:  wr_val = WIDE_W'(sat_sum(SUM_W'(opa) - SUM_W'(opb)));
			OP_ADD:  wr_val = WIDE_W'(sat_sum(SUM_W'(opa) + SUM_W'(opb)));
			OP_ACC: begin
				case (u.w)
					W_SET:   wr_val = opa;
					W_ONE:   wr_val = opb + opa;
					default: wr_val = opb + (opa <<< 1);
				endcase
			end
			OP_MUL:  wr_val = WIDE_W'(sat_mag(mq, neg));
			OP_MULF: wr_val = $signed({1'b0, mf_val[WIDE_W-2:0]});
			OP_DIV:  wr_val = WIDE_W'(sat_mag(mq, neg_q));
			default: wr_val = '0;
		endcase
	end

	assign wr_en = ((state_q == SQ_EXEC) && !is_mul && (u.op != OP_NOP))
		|| ((state_q == SQ_WAIT) && mdone);
	assign adv   = ((state_q == SQ_EXEC) && !is_mul) || ((state_q == SQ_WAIT) && mdone);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SQ_IDLE;
			stage_q <= '0;
			slot_q  <= '0;
		end else begin
			case (state_q)
				SQ_IDLE: begin
					if (cmd.go) begin
						state_q <= SQ_EXEC;
						stage_q <= '0;
						slot_q  <= '0;
					end
				end
				SQ_EXEC: begin
					if (is_mul)
						state_q <= SQ_WAIT;
				end
				SQ_WAIT: begin
					if (mdone)
						state_q <= SQ_EXEC;
				end
				SQ_DONE: begin
					if (fin_ok)
						state_q <= SQ_IDLE;
				end
				default: state_q <= SQ_IDLE;
			endcase
			if (adv) begin
				if (slot_q == last_slot(stage_q)) begin
					slot_q <= '0;
					if (stage_q == 2'd3)
						state_q <= SQ_DONE;
					else
						stage_q <= stage_q + 1'b1;
				end else begin
					slot_q <= slot_q + 1'b1;
				end
			end
		end
	end

	// position registers: reset to the start defaults
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			y0_q <= RST_POS;
			y1_q <= RST_POS;
			y2_q <= RST_POS;
		end else if (state_q == SQ_IDLE && cmd.load) begin
			y0_q <= start.x;
			y1_q <= start.y;
			y2_q <= start.z;
		end else if (wr_en) begin
			case (u.d)
				DST_Y0:  y0_q <= wr_val[VAL_W-1:0];
				DST_Y1:  y1_q <= wr_val[VAL_W-1:0];
				DST_Y2:  y2_q <= wr_val[VAL_W-1:0];
				default: ;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (state_q == SQ_IDLE && cmd.go) begin
			s0_q <= y0_q;
			s1_q <= y1_q;
			s2_q <= y2_q;
		end else if (wr_en) begin
			case (u.d)
				DST_S0: s0_q <= wr_val[VAL_W-1:0];
				DST_S1: s1_q <= wr_val[VAL_W-1:0];
				DST_S2: s2_q <= wr_val[VAL_W-1:0];
				DST_K0: k0_q <= wr_val[VAL_W-1:0];
				DST_K1: k1_q <= wr_val[VAL_W-1:0];
				DST_K2: k2_q <= wr_val[VAL_W-1:0];
				DST_T:  t_q  <= wr_val[ACC_W-1:0];
				DST_T2: t2_q <= wr_val[VAL_W-1:0];
				DST_A0: a0_q <= wr_val[ACC_W-1:0];
				DST_A1: a1_q <= wr_val[ACC_W-1:0];
				DST_A2: a2_q <= wr_val[ACC_W-1:0];
				default: ;
			endcase
		end
		// sign of the weighted k sum, kept for the divide
		if (wr_en && u.op == OP_MULF)
			neg_q <= opa[WIDE_W-1];
	end

	assign sts.idle = (state_q == SQ_IDLE);
	assign sts.done = (state_q == SQ_DONE);
	assign pos.x    = y0_q;
	assign pos.y    = y1_q;
	assign pos.z    = y2_q;

endmodule
`default_nettype wire

/* design/lorenz_rk4_integrator.sv */
// Lorenz attractor integrator, one RK4 step per advance item: top level.
// An advance item runs 31 products on the shared 44x16 multiplier and 40 add/compare
// micro-ops, then hands off; its result is registered for output only past the transient
// count and on the stride grid. A restart reloads the start position.
// The input takes no new advance item until the step has finished and been handed off,
// and the hand-off waits while a result is held; restarts can follow each other every cycle.
// Reset: arst_n clears control, restores register defaults and the start position.
`timescale 1ns / 1ps
`default_nettype none
module lorenz_rk4_integrator
	import lrk4_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [7:0]          s_tdata,   // [0] restart
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [151:0]             m_tdata,   // [31:0] step_index, [71:32] out_x,
	                                            // [111:72] out_y, [151:112] out_z
	input  wire logic                cfg_we,
	input  wire logic [CFG_AW-1:0]   cfg_addr,
	input  wire logic [CFG_DW-1:0]   cfg_wdata
);

	coef_t               coef_q;
	pos_t                start_q;
	logic [TRANS_W-1:0]  trans_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [PHASE_W-1:0]  phase_q;
	logic                m_valid_q;
	logic [151:0]        m_data_q;

	core_cmd_t cmd;
	core_sts_t sts;
	pos_t      pos;
	logic      accept;
	logic      fin_ok;
	logic      commit;
	logic      emit;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q.h     <= RST_STEP;
			coef_q.sigma <= RST_SIGMA;
			coef_q.rho   <= RST_RHO;
			coef_q.beta  <= RST_BETA;
			start_q.x    <= RST_POS;
			start_q.y    <= RST_POS;
			start_q.z    <= RST_POS;
			trans_q      <= RST_TRANS;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_addr))
				REG_STEP:  coef_q.h     <= cfg_wdata[H_W-1:0];
				REG_SIGMA: coef_q.sigma <= cfg_wdata[COEF_W-1:0];
				REG_RHO:   coef_q.rho   <= cfg_wdata[COEF_W-1:0];
				REG_BETA:  coef_q.beta  <= cfg_wdata[COEF_W-1:0];
				REG_SX:    start_q.x    <= cfg_wdata[VAL_W-1:0];
				REG_SY:    start_q.y    <= cfg_wdata[VAL_W-1:0];
				REG_SZ:    start_q.z    <= cfg_wdata[VAL_W-1:0];
				REG_TRANS: trans_q      <= cfg_wdata[TRANS_W-1:0];
				default: ;
			endcase
		end
	end

	// input handshake
	assign s_tready = sts.idle;
	assign accept   = s_tvalid && s_tready;
	assign cmd.go   = accept && !s_tdata[0];
	assign cmd.load = accept && s_tdata[0];

	lrk4_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.coef   (coef_q),
		.start  (start_q),
		.fin_ok (fin_ok),
		.sts    (sts),
		.pos    (pos)
	);

	// step finishes once the output register can take its result
	assign fin_ok = !m_valid_q || m_tready;
	assign commit = sts.done && fin_ok;
	assign emit   = (({1'b0, cnt_q} + (CNT_W + 1)'(1)) >= (CNT_W + 1)'(trans_q))
		&& (phase_q == '0);

	// step count and stride phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			phase_q <= '0;
		end else if (cmd.load) begin
			cnt_q   <= '0;
			phase_q <= '0;
		end else if (commit) begin
			if (cnt_q != '1)
				cnt_q <= cnt_q + 1'b1;
			phase_q <= (phase_q == PHASE_W'(STRIDE - 1)) ? '0 : phase_q + 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (commit && emit) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit && emit)
			m_data_q <= {pos.z, pos.y, pos.x, cnt_q};
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	// an advance item keeps the input closed while the step runs
	a_busy_after_go: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.go |=> !s_tready)
		else $error("input open during a step");

	// phase stays on the stride grid
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q <= PHASE_W'(STRIDE - 1))
		else $error("stride phase out of range");

	// count only moves back on a restart
	a_count_mono: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.load |=> cnt_q >= $past(cnt_q))
		else $error("step count went backwards");

	// a finished step never overwrites a waiting result
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && !m_tready |-> !commit)
		else $error("result overwritten");

endmodule
`default_nettype wire
